// ----- hdl/rig_pkg.sv -----
`default_nettype none
package rig_pkg;

    // field widths
    localparam int AMP_W    = 16;
    localparam int DENS_W   = 24;
    localparam int RATE_W   = 32;
    localparam int PRNG_W   = 31;
    localparam int THR_W    = 32;
    localparam int RECIP_W  = 48;
    localparam int Q_W      = 16;
    localparam int TPROD_W  = DENS_W + RATE_W;
    localparam int HALF_W   = RECIP_W / 2;
    localparam int PART_W   = PRNG_W + HALF_W;
    localparam int FACTOR_W = Q_W + 2;
    localparam int SPROD_W  = AMP_W + FACTOR_W;
    localparam int CNT_W    = 6;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    // lcg and fixed-point constants
    localparam logic [PRNG_W-1:0] LCG_MUL  = 31'd1103515245;
    localparam logic [PRNG_W-1:0] LCG_INC  = 31'd12345;
    localparam logic [PRNG_W-1:0] PRNG_RST = 31'd1;
    localparam logic [THR_W-1:0]  Q31_ONE  = 32'h8000_0000;
    localparam logic [RATE_W-1:0] RATE_RST = 32'd89478;
    localparam logic [CNT_W-1:0]  DIV_LAST = CNT_W'(RECIP_W - 1);

    // configuration register indexes
    localparam logic REG_BIPOLAR_MODE        = 1'b0;
    localparam logic REG_INVERSE_SAMPLE_RATE = 1'b1;

    // microcode
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [3:0] {
        OP_WAIT,
        OP_CHECK,
        OP_TMUL,
        OP_TSAT,
        OP_DIVINIT,
        OP_DIVSTEP,
        OP_LCG,
        OP_CMP,
        OP_MULHI,
        OP_MULLO,
        OP_SUMQ,
        OP_SCALE,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_SAME_DENS,
        JC_THR_ZERO,
        JC_DIV_MORE,
        JC_NO_FIRE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctl_word_t;

    // program step addresses
    localparam step_t S_WAIT    = 4'd0;
    localparam step_t S_CHECK   = 4'd1;
    localparam step_t S_TMUL    = 4'd2;
    localparam step_t S_TSAT    = 4'd3;
    localparam step_t S_DIVINIT = 4'd4;
    localparam step_t S_DIVSTEP = 4'd5;
    localparam step_t S_LCG     = 4'd6;
    localparam step_t S_CMP     = 4'd7;
    localparam step_t S_MULHI   = 4'd8;
    localparam step_t S_MULLO   = 4'd9;
    localparam step_t S_SUMQ    = 4'd10;
    localparam step_t S_SCALE   = 4'd11;
    localparam step_t S_EMIT    = 4'd12;

    // control store: one word per step
    function automatic ctl_word_t ucode(input step_t step);
        ctl_word_t w;
        unique case (step)
            S_WAIT:    w = '{OP_WAIT,    JC_NEXT,      S_WAIT};
            S_CHECK:   w = '{OP_CHECK,   JC_SAME_DENS, S_LCG};
            S_TMUL:    w = '{OP_TMUL,    JC_NEXT,      S_WAIT};
            S_TSAT:    w = '{OP_TSAT,    JC_NEXT,      S_WAIT};
            S_DIVINIT: w = '{OP_DIVINIT, JC_THR_ZERO,  S_LCG};
            S_DIVSTEP: w = '{OP_DIVSTEP, JC_DIV_MORE,  S_DIVSTEP};
            S_LCG:     w = '{OP_LCG,     JC_NEXT,      S_WAIT};
            S_CMP:     w = '{OP_CMP,     JC_NO_FIRE,   S_EMIT};
            S_MULHI:   w = '{OP_MULHI,   JC_NEXT,      S_WAIT};
            S_MULLO:   w = '{OP_MULLO,   JC_NEXT,      S_WAIT};
            S_SUMQ:    w = '{OP_SUMQ,    JC_NEXT,      S_WAIT};
            S_SCALE:   w = '{OP_SCALE,   JC_NEXT,      S_WAIT};
            S_EMIT:    w = '{OP_EMIT,    JC_ALWAYS,    S_WAIT};
            default:   w = '{OP_WAIT,    JC_ALWAYS,    S_WAIT};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/random_impulse_generator.sv -----
`default_nettype none
// Random impulse ("dust") source, one transfer per audio tick.
// s_axis carries amplitude and density; each accepted transfer gives exactly
// one m_axis transfer with the sample and a fired flag.
// A 31-bit LCG is stepped each tick; a tick fires when the new value is below
// a threshold derived from density times the inverse sample rate.
// Control is a 13-step microprogram; s_axis_tready is high only at the wait step.
// From accept: check; on a new density, threshold multiply, saturate and
// divider init, then the bit-serial 48-step reciprocal divider unless the new
// threshold is zero; then the lcg step and compare; on a fire, the high and
// low products, the sum and the scale step; then emit, and back to wait.
// The result sits in an output register, so a stalled receiver holds only the
// final step; the next item is taken and worked on while a result waits.
// Reset clears the generator state to seed 1, threshold and reciprocal to 0,
// bipolar_mode to 0 and inverse_sample_rate to the 48 kHz value.
// Registers are to be written through cfg_we/cfg_index/cfg_data only while
// idle; this binds the user, the block itself does not enforce it.
module random_impulse_generator (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // amplitude [15:0], density [39:16]
    input  wire logic [rig_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // sample_out [15:0]
    output logic [rig_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // fired [0]
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    input  wire logic                            cfg_we,
    input  wire logic                            cfg_index,
    input  wire logic [rig_pkg::RATE_W-1:0]      cfg_data
);
    import rig_pkg::*;

    // sequencer
    step_t     pc_reg, pc_next;
    ctl_word_t ctl;
    logic      stall, cond_true, exec;

    // configuration and architectural state
    logic                       mode_reg, mode_next;
    logic [RATE_W-1:0]          isr_reg, isr_next;
    logic [PRNG_W-1:0]          prng_reg, prng_next;
    logic [DENS_W-1:0]          last_dens_reg, last_dens_next;
    logic [THR_W-1:0]           thr_reg, thr_next;
    logic [RECIP_W-1:0]         recip_reg, recip_next;

    // working registers
    logic signed [AMP_W-1:0]    amp_reg, amp_next;
    logic [DENS_W-1:0]          dens_reg, dens_next;
    logic [TPROD_W-1:0]         tprod_reg, tprod_next;
    logic [THR_W-1:0]           rem_reg, rem_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [PART_W-1:0]          hi_reg, hi_next;
    logic [PART_W-1:0]          lo_reg, lo_next;
    logic [Q_W-1:0]             q_reg, q_next;
    logic signed [SPROD_W-1:0]  sprod_reg, sprod_next;
    logic                       fired_reg, fired_next;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic [AMP_W-1:0]           out_sample_reg, out_sample_next;
    logic                       out_fired_reg, out_fired_next;

    // datapath helpers
    logic [TPROD_W-10:0]        t_shift;
    logic [THR_W-1:0]           thr_sat;
    logic [THR_W:0]             div_shift, div_diff;
    logic                       div_ge;
    logic [PRNG_W-1:0]          lcg_val;
    logic                       fire_now;
    logic [PART_W:0]            q_sum;
    logic signed [FACTOR_W-1:0] factor;
    logic signed [FACTOR_W-1:0] samp_wide;
    logic [AMP_W-1:0]           samp_sat;
    logic                       out_free;

    // threshold saturation
    assign t_shift = tprod_reg[TPROD_W-1:9];
    assign thr_sat = (t_shift > (TPROD_W-9)'(Q31_ONE)) ? Q31_ONE : t_shift[THR_W-1:0];

    // restoring divider step, dividend 2^47 feeds its one bit at the first step
    assign div_shift = {rem_reg, (cnt_reg == DIV_LAST)};
    assign div_ge    = div_shift >= {1'b0, thr_reg};
    assign div_diff  = div_shift - {1'b0, thr_reg};

    // lcg, low 31 bits only
    assign lcg_val  = prng_reg * LCG_MUL + LCG_INC;
    assign fire_now = {1'b0, prng_reg} < thr_reg;

    // ratio and impulse factor
    assign q_sum  = {1'b0, hi_reg} + {{(HALF_W+1){1'b0}}, lo_reg[PART_W-1:HALF_W]};
    assign factor = mode_reg ? ($signed({1'b0, q_reg, 1'b0}) - FACTOR_W'(65536))
                             : $signed({2'b00, q_reg});

    // final scaling and saturation
    assign samp_wide = sprod_reg[SPROD_W-1:Q_W];
    always_comb
    begin
        if (samp_wide > FACTOR_W'(32767))
            samp_sat = 16'h7FFF;
        else if (samp_wide < -FACTOR_W'(32768))
            samp_sat = 16'h8000;
        else
            samp_sat = samp_wide[AMP_W-1:0];
    end

    // sequencer control
    assign out_free = !out_valid_reg || m_axis_tready;
    assign ctl      = ucode(pc_reg);
    assign stall    = ((ctl.op == OP_WAIT) && !s_axis_tvalid) ||
                      ((ctl.op == OP_EMIT) && !out_free);
    assign exec     = !stall;

    always_comb
    begin
        case (ctl.cond)
            JC_NEXT:      cond_true = 1'b0;
            JC_ALWAYS:    cond_true = 1'b1;
            JC_SAME_DENS: cond_true = (dens_reg == last_dens_reg);
            JC_THR_ZERO:  cond_true = (thr_reg == '0);
            JC_DIV_MORE:  cond_true = (cnt_reg != '0);
            JC_NO_FIRE:   cond_true = !fire_now;
            default:      cond_true = 1'b0;
        endcase
        if (stall)
            pc_next = pc_reg;
        else if (cond_true)
            pc_next = ctl.target;
        else
            pc_next = pc_reg + step_t'(1);
    end

    assign s_axis_tready = (ctl.op == OP_WAIT);

    // datapath next values
    always_comb
    begin
        mode_next       = mode_reg;
        isr_next        = isr_reg;
        prng_next       = prng_reg;
        last_dens_next  = last_dens_reg;
        thr_next        = thr_reg;
        recip_next      = recip_reg;
        amp_next        = amp_reg;
        dens_next       = dens_reg;
        tprod_next      = tprod_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        hi_next         = hi_reg;
        lo_next         = lo_reg;
        q_next          = q_reg;
        sprod_next      = sprod_reg;
        fired_next      = fired_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_sample_next = out_sample_reg;
        out_fired_next  = out_fired_reg;

        // register writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BIPOLAR_MODE:        mode_next = cfg_data[0];
                REG_INVERSE_SAMPLE_RATE: isr_next  = cfg_data;
                default:                 mode_next = mode_reg;
            endcase
        end

        if (exec)
        begin
            unique case (ctl.op)
                OP_WAIT:
                begin
                    amp_next  = $signed(s_axis_tdata[AMP_W-1:0]);
                    dens_next = s_axis_tdata[AMP_W +: DENS_W];
                end
                OP_CHECK:
                begin
                    // clears the fired flag; the decision is taken by the jump condition
                    fired_next = 1'b0;
                end
                OP_TMUL:
                begin
                    tprod_next = TPROD_W'(dens_reg) * TPROD_W'(isr_reg);
                end
                OP_TSAT:
                begin
                    thr_next       = thr_sat;
                    last_dens_next = dens_reg;
                end
                OP_DIVINIT:
                begin
                    recip_next = '0;
                    rem_next   = '0;
                    cnt_next   = DIV_LAST;
                end
                OP_DIVSTEP:
                begin
                    rem_next   = div_ge ? div_diff[THR_W-1:0] : div_shift[THR_W-1:0];
                    recip_next = {recip_reg[RECIP_W-2:0], div_ge};
                    cnt_next   = cnt_reg - CNT_W'(1);
                end
                OP_LCG:
                begin
                    prng_next = lcg_val;
                end
                OP_CMP:
                begin
                    fired_next = fire_now;
                end
                OP_MULHI:
                begin
                    hi_next = PART_W'(prng_reg) * PART_W'(recip_reg[RECIP_W-1:HALF_W]);
                end
                OP_MULLO:
                begin
                    lo_next = PART_W'(prng_reg) * PART_W'(recip_reg[HALF_W-1:0]);
                end
                OP_SUMQ:
                begin
                    q_next = q_sum[7 +: Q_W];
                end
                OP_SCALE:
                begin
                    sprod_next = amp_reg * factor;
                end
                OP_EMIT:
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = fired_reg ? samp_sat : '0;
                    out_fired_next  = fired_reg;
                end
                default:
                begin
                    fired_next = fired_reg;
                end
            endcase
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= S_WAIT;
            mode_reg      <= 1'b0;
            isr_reg       <= RATE_RST;
            prng_reg      <= PRNG_RST;
            last_dens_reg <= '0;
            thr_reg       <= '0;
            recip_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            mode_reg      <= mode_next;
            isr_reg       <= isr_next;
            prng_reg      <= prng_next;
            last_dens_reg <= last_dens_next;
            thr_reg       <= thr_next;
            recip_reg     <= recip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        amp_reg        <= amp_next;
        dens_reg       <= dens_next;
        tprod_reg      <= tprod_next;
        rem_reg        <= rem_next;
        cnt_reg        <= cnt_next;
        hi_reg         <= hi_next;
        lo_reg         <= lo_next;
        q_reg          <= q_next;
        sprod_reg      <= sprod_next;
        fired_reg      <= fired_next;
        out_sample_reg <= out_sample_next;
        out_fired_reg  <= out_fired_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sample_reg;
    assign m_axis_tuser  = out_fired_reg;

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic REG_MODE = rig_pkg::REG_BIPOLAR_MODE;
    localparam logic REG_RATE = rig_pkg::REG_INVERSE_SAMPLE_RATE;

    localparam logic [31:0] RATE_48K = 32'd89478;
    localparam longint unsigned LCG_A = 64'd1103515245;
    localparam longint unsigned LCG_C = 64'd12345;
    localparam longint unsigned THR_ONE = 64'h8000_0000;

    localparam int HOLD_OFF_CYCLES = 200;
    localparam int IDLE_LIMIT = 2000;
    localparam int QUIET_CYCLES = 4;
    localparam int TAIL_CYCLES = 70;
    localparam int PHASE_TICKS = 112;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [15:0] sample;
        logic        fired;
    } tick_out_t;

    typedef struct packed {
        logic      pinned;
        tick_out_t value;
    } typed_t;

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic        idx;
        logic [31:0] val;
        logic [15:0] amp;
        logic [23:0] dens;
        logic        pinned;
        tick_out_t   pin;
    } row_t;

    // directed stimulus; pinned rows carry a result that is obvious by inspection
    localparam row_t PLAN [26] = '{
        // after reset: zero threshold, nothing fires
        '{ROW_TICK,  REG_MODE, 32'd0, 16'h7FFF, 24'h000000, 1'b1, '{16'h0000, 1'b0}},
        '{ROW_TICK,  REG_MODE, 32'd0, 16'h8000, 24'h000000, 1'b1, '{16'h0000, 1'b0}},
        // full density saturates the threshold so those ticks fire, then lower densities
        '{ROW_TICK,  REG_MODE, 32'd0, 16'h7FFF, 24'hFFFFFF, 1'b0, '{16'h0000, 1'b0}},
        '{ROW_TICK,  REG_MODE, 32'd0, 16'h8000, 24'hFFFFFF, 1'b0, '{16'h0000, 1'b0}},
        '{ROW_TICK,  REG_MODE, 32'd0, 16'h0000, 24'hFFFFFF, 1'b1, '{16'h0000, 1'b1}},
        '{ROW_TICK,  REG_MODE, 32'd0, 16'h7FFF, 24'h000001, 1'b0, '{16'h0000, 1'b0}},
        '{ROW_TICK,  REG_MODE, 32'd0, 16'h8000, 24'hBB8000, 1'b0, '{16'h0000, 1'b0}},
        '{ROW_TICK,  REG_MODE, 32'd0, 16'h1234, 24'h5A5A5A, 1'b0, '{16'h0000, 1'b0}},
        // bipolar impulses
        '{ROW_WRITE, REG_MODE, 32'd1, 16'h0000, 24'h000000, 1'b0, '{16'h0000, 1'b0}},
        '{ROW_TICK,  REG_MODE, 32'd0, 16'h7FFF, 24'hFFFFFF, 1'b0, '{16'h0000, 1'b0}},
        '{ROW_TICK,  REG_MODE, 32'd0, 16'h8000, 24'hFFFFFF, 1'b0, '{16'h0000, 1'b0}},
        '{ROW_TICK,  REG_MODE, 32'd0, 16'h0000, 24'hFFFFFF, 1'b1, '{16'h0000, 1'b1}},
        '{ROW_TICK,  REG_MODE, 32'd0, 16'h8000, 24'hBB8000, 1'b0, '{16'h0000, 1'b0}},
        '{ROW_TICK,  REG_MODE, 32'd0, 16'h7FFF, 24'hA5A5A5, 1'b0, '{16'h0000, 1'b0}},
        // max rate: old threshold kept until the density moves
        '{ROW_WRITE, REG_RATE, 32'hFFFF_FFFF, 16'h0000, 24'h000000, 1'b0, '{16'h0000, 1'b0}},
        '{ROW_TICK,  REG_MODE, 32'd0, 16'h7FFF, 24'hA5A5A5, 1'b0, '{16'h0000, 1'b0}},
        '{ROW_TICK,  REG_MODE, 32'd0, 16'h8000, 24'h000001, 1'b0, '{16'h0000, 1'b0}},
        // just below and just above the saturation point
        '{ROW_TICK,  REG_MODE, 32'd0, 16'h7FFF, 24'h000100, 1'b0, '{16'h0000, 1'b0}},
        '{ROW_TICK,  REG_MODE, 32'd0, 16'h7FFF, 24'h000101, 1'b0, '{16'h0000, 1'b0}},
        // zero rate gives a zero threshold on the next density change
        '{ROW_WRITE, REG_RATE, 32'd0, 16'h0000, 24'h000000, 1'b0, '{16'h0000, 1'b0}},
        '{ROW_TICK,  REG_MODE, 32'd0, 16'h7FFF, 24'hFFFFFF, 1'b1, '{16'h0000, 1'b0}},
        '{ROW_TICK,  REG_MODE, 32'd0, 16'h8000, 24'h000000, 1'b1, '{16'h0000, 1'b0}},
        // back to defaults
        '{ROW_WRITE, REG_MODE, 32'd0, 16'h0000, 24'h000000, 1'b0, '{16'h0000, 1'b0}},
        '{ROW_WRITE, REG_RATE, RATE_48K, 16'h0000, 24'h000000, 1'b0, '{16'h0000, 1'b0}},
        '{ROW_TICK,  REG_MODE, 32'd0, 16'h5555, 24'hAAAAAA, 1'b0, '{16'h0000, 1'b0}},
        '{ROW_TICK,  REG_MODE, 32'd0, 16'hAAAA, 24'h555555, 1'b0, '{16'h0000, 1'b0}}
    };

    localparam int GAP_BY_PHASE [4] = '{0, 53, 0, 21};
    localparam int STALL_BY_PHASE [4] = '{0, 0, 53, 21};

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic [rig_pkg::IN_DATA_W-1:0]     s_axis_tdata;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [rig_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
    logic                              m_axis_tuser;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic                              cfg_we;
    logic                              cfg_index;
    logic [rig_pkg::RATE_W-1:0]        cfg_data;

    // predictor state and register copies
    logic [30:0] lcg_state;
    logic [23:0] held_density;
    logic [31:0] fire_thr;
    logic [47:0] recip_scale;
    logic        mode_bipolar;
    logic [31:0] inv_rate;

    tick_out_t   pending_ticks[$];
    typed_t      typed_results[$];
    int          mismatches = 0;
    int          send_gap_pct = 0;
    int          stall_pct = 0;
    int          hold_left = 0;
    logic [23:0] last_dens = '0;

    random_impulse_generator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 125 MHz clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // one audio tick: threshold update, lcg step, impulse scaling
    function automatic tick_out_t dust_tick(input logic signed [15:0] amp,
                                            input logic [23:0] dens);
        longint unsigned thr_wide;
        longint unsigned r;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned q;
        longint          factor;
        longint          prod;
        longint          level;
        tick_out_t       res;
        if (dens != held_density)
        begin
            thr_wide = dens;
            thr_wide = (thr_wide * inv_rate) >> 9;
            if (thr_wide > THR_ONE)
                thr_wide = THR_ONE;
            fire_thr = thr_wide[31:0];
            recip_scale = (thr_wide != 0) ? 48'((64'd1 << 47) / thr_wide) : '0;
            held_density = dens;
        end
        r = lcg_state;
        r = r * LCG_A + LCG_C;
        lcg_state = r[30:0];
        res = '0;
        if (lcg_state < fire_thr)
        begin
            // ratio r / threshold in q0.16 via the stored reciprocal
            r = lcg_state;
            hi = r * recip_scale[47:24];
            lo = r * recip_scale[23:0];
            q = (hi + (lo >> 24)) >> 7;
            factor = q;
            if (mode_bipolar)
                factor = 2 * factor - 65536;
            prod = amp;
            prod = prod * factor;
            level = prod >>> 16;
            if (level > 32767)
                level = 32767;
            else if (level < -32768)
                level = -32768;
            res.sample = level[15:0];
            res.fired = 1'b1;
        end
        return res;
    endfunction

    function automatic logic [31:0] pick_rate();
        case ($urandom_range(4))
            0: return RATE_48K;
            1: return 32'd0;
            2: return 32'hFFFF_FFFF;
            3: return 32'($urandom());
            default: return 32'($urandom_range(200000));
        endcase
    endfunction

    // density held half the time, otherwise jumping to extremes or random values
    function automatic logic [23:0] next_density();
        case ($urandom_range(9))
            5: last_dens = '0;
            6: last_dens = 24'hFFFFFF;
            7: last_dens = 24'($urandom_range(255));
            8, 9: last_dens = 24'($urandom());
            default: ;
        endcase
        return last_dens;
    endfunction

    function automatic logic [15:0] pick_amplitude();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom());
        endcase
    endfunction

    // offer one tick and hold it until the transfer
    task automatic offer_tick(input logic [15:0] amp, input logic [23:0] dens,
                              input logic pinned, input tick_out_t pin);
        if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_gap_pct);
        end
        typed_results.push_back('{pinned, pin});
        s_axis_tdata <= {dens, amp};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // stop sending until every result is back, then let the block go idle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_ticks.size() != 0);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        settle();
        cfg_index <= idx;
        cfg_data <= val;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_MODE)
            mode_bipolar = val[0];
        else
            inv_rate = val;
    endtask

    // receiver: random stalls plus one long hold-off
    initial
    begin : receiver
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // predict on each input transfer, check each output transfer
    always @(posedge clk)
    begin : scoreboard
        tick_out_t want;
        typed_t    typed;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            want = dust_tick(s_axis_tdata[15:0], s_axis_tdata[39:16]);
            typed = typed_results.pop_front();
            if (typed.pinned)
                want = typed.value;
            pending_ticks.push_back(want);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_ticks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: sample %0d fired %0b",
                             $signed(m_axis_tdata), m_axis_tuser);
            end
            else
            begin
                want = pending_ticks.pop_front();
                if (m_axis_tdata !== want.sample || m_axis_tuser !== want.fired)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result wrong: expected sample %0d fired %0b, got %0d %0b",
                                 $signed(want.sample), want.fired,
                                 $signed(m_axis_tdata), m_axis_tuser);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_we || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        int phase;
        int n;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = REG_MODE;
        cfg_data = '0;
        rst_n = 1'b0;
        lcg_state = 31'd1;
        held_density = '0;
        fire_thr = '0;
        recip_scale = '0;
        mode_bipolar = 1'b0;
        inv_rate = RATE_48K;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (PLAN[i])
        begin
            if (PLAN[i].kind == ROW_WRITE)
                write_reg(PLAN[i].idx, PLAN[i].val);
            else
                offer_tick(PLAN[i].amp, PLAN[i].dens, PLAN[i].pinned, PLAN[i].pin);
        end
        last_dens = 24'h555555;

        // random phases with fresh register settings and idling patterns
        for (phase = 0; phase < 4; phase++)
        begin
            write_reg(REG_MODE, 32'($urandom_range(1)));
            write_reg(REG_RATE, pick_rate());
            send_gap_pct = GAP_BY_PHASE[phase];
            stall_pct = STALL_BY_PHASE[phase];
            for (n = 0; n < PHASE_TICKS; n++)
            begin
                // receiver holds off while ticks keep coming
                if (phase == 0 && n == 40)
                    hold_left = HOLD_OFF_CYCLES;
                // sender pauses until the output side has caught up
                if (phase == 1 && n == 60)
                    settle();
                offer_tick(pick_amplitude(), next_density(), 1'b0, '0);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_ticks.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/rig_pkg.sv
hdl/random_impulse_generator.sv
tb/testbench.sv
